// File: rtl/jqts_pkg.sv
// Shared types and constants for the jet qualify and top-k select block.
package jqts_pkg;

  localparam int PT_W     = 16;
  localparam int ETA_W    = 11;
  localparam int EDGE_W   = 10;
  localparam int SPREAD_W = 10;
  localparam int BETA_W   = 11;
  localparam int IDX_W    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_B     = 4;
  localparam int NUM_LIGHT = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PT_MIN            = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_LIMIT         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BARREL_EDGE       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENDCAP_EDGE       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_MAX_BARREL = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_MAX_BARREL   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_MAX_ENDCAP = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_MAX_ENDCAP   = 4'd7;

  typedef struct packed {
    logic [PT_W-1:0]     pt_min;
    logic [EDGE_W-1:0]   eta_limit;
    logic [EDGE_W-1:0]   barrel_edge;
    logic [EDGE_W-1:0]   endcap_edge;
    logic [SPREAD_W-1:0] spread_max_barrel;
    logic [BETA_W-1:0]   beta_max_barrel;
    logic [SPREAD_W-1:0] spread_max_endcap;
    logic [BETA_W-1:0]   beta_max_endcap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pt_min:            16'd160,
    eta_limit:         10'd500,
    barrel_edge:       10'd150,
    endcap_edge:       10'd400,
    spread_max_barrel: 10'd72,
    beta_max_barrel:   11'd891,
    spread_max_endcap: 10'd72,
    beta_max_endcap:   11'd870
  };

  typedef struct packed {
    logic [PT_W-1:0]     pt;
    logic [ETA_W-1:0]    eta;
    logic                btag;
    logic [SPREAD_W-1:0] spread;
    logic [BETA_W-1:0]   beta_star;
    logic                last_jet;
  } jet_t;

  typedef struct packed {
    logic insert;
    logic clear;
  } slot_ctrl_t;

endpackage

// File: rtl/jqts_qualify.sv
// Jet quality check: pile-up ID by eta region plus pt and eta cuts.
module jqts_qualify
  import jqts_pkg::*;
(
  input  jet_t cfg_jet,
  input  cfg_t cfg,
  output logic pass
);

  logic [ETA_W-1:0] abs_eta;
  logic             id_ok;

  always_comb begin
    abs_eta = cfg_jet.eta[ETA_W-1] ? (ETA_W'(0) - cfg_jet.eta) : cfg_jet.eta;
    priority if (abs_eta < {1'b0, cfg.barrel_edge}) begin
      id_ok = (cfg_jet.spread < cfg.spread_max_barrel) &&
              (cfg_jet.beta_star < cfg.beta_max_barrel);
    end else if (abs_eta < {1'b0, cfg.endcap_edge}) begin
      id_ok = (cfg_jet.spread < cfg.spread_max_endcap) &&
              (cfg_jet.beta_star < cfg.beta_max_endcap);
    end else begin
      id_ok = 1'b0;
    end
    pass = id_ok && (cfg_jet.pt > cfg.pt_min) && (abs_eta < {1'b0, cfg.eta_limit});
  end

endmodule

// File: rtl/jqts_slots.sv
// Sorted slot list: inserts a jet on strictly greater pt, shifting lower slots down.
module jqts_slots
  import jqts_pkg::*;
#(
  parameter int NUM_SLOTS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  slot_ctrl_t           ctrl,
  input  logic [PT_W-1:0]      pt,
  input  logic [IDX_W-1:0]     idx,
  output logic [NUM_SLOTS-1:0] full_next,
  output logic [IDX_W-1:0]     idx_next [NUM_SLOTS]
);

  logic [PT_W-1:0]      slot_pt      [NUM_SLOTS];
  logic [IDX_W-1:0]     slot_idx     [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_full;
  logic [PT_W-1:0]      slot_pt_next [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] take;

  always_comb begin
    logic found;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      take[k] = ctrl.insert && (!slot_full[k] || (pt > slot_pt[k]));
    end
    slot_pt_next = slot_pt;
    idx_next     = slot_idx;
    full_next    = slot_full;
    if (take[0]) begin
      slot_pt_next[0] = pt;
      idx_next[0]     = idx;
      full_next[0]    = 1'b1;
    end
    found = take[0];
    for (int k = 1; k < NUM_SLOTS; k++) begin
      if (found) begin
        slot_pt_next[k] = slot_pt[k-1];
        idx_next[k]     = slot_idx[k-1];
        full_next[k]    = slot_full[k-1];
      end else if (take[k]) begin
        slot_pt_next[k] = pt;
        idx_next[k]     = idx;
        full_next[k]    = 1'b1;
      end
      found = found || take[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      slot_full <= '0;
    end else begin
      slot_full <= full_next;
    end
    slot_pt  <= slot_pt_next;
    slot_idx <= idx_next;
  end

endmodule

// File: rtl/jet_qualify_topk_select_core.sv
// Top level: input register, jet qualification, b and light slot lists, result register.
//
// One jet word enters on the input channel (in_valid / in_stall) per cycle unless stalled.
// Each jet is tagged with a running index, checked against the pile-up ID
// and the pt and eta cuts, and a qualified jet is placed into the four b
// slots or the two light slots, sorted by pt. Jets past MAX_JETS in one
// event are counted out and not placed.
// The jet marked last_jet produces one result word on the output channel
// (out_valid / out_stall), loaded into the result register as that jet leaves
// the input register: the slot indices, slot_valid and complete. The slots and
// the index counter then clear.
// Throughput is one jet per cycle; each slot list computes its next state combinationally.
// A stalled result holds; jets that are not last keep flowing, and only a
// last jet waits in the input register while a previous result is stalled.
// Configuration is written through cfg_write / cfg_index / cfg_data, by the
// user only while idle (not enforced by the block); unknown indices are ignored.
// Reset (rst, synchronous) restores default cuts and empties all slots.
module jet_qualify_topk_select_core
  import jqts_pkg::*;
#(
  parameter int MAX_JETS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PT_W-1:0]       pt,
  input  logic [ETA_W-1:0]      eta,
  input  logic                  btag,
  input  logic [SPREAD_W-1:0]   spread,
  input  logic [BETA_W-1:0]     beta_star,
  input  logic                  last_jet,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      b_first,
  output logic [IDX_W-1:0]      b_second,
  output logic [IDX_W-1:0]      b_third,
  output logic [IDX_W-1:0]      b_fourth,
  output logic [IDX_W-1:0]      light_first,
  output logic [IDX_W-1:0]      light_second,
  output logic [NUM_B+NUM_LIGHT-1:0] slot_valid,
  output logic                  complete
);

  localparam int CNT_W = $clog2(MAX_JETS + 1);

  cfg_t             cfg;
  jet_t             jet;
  logic             jet_valid;
  logic             advance;
  logic             pass;
  logic             in_range;
  logic [CNT_W-1:0] next_index;
  logic [IDX_W-1:0] jet_idx;
  slot_ctrl_t       b_ctrl;
  slot_ctrl_t       l_ctrl;
  logic [NUM_B-1:0]     b_full_next;
  logic [IDX_W-1:0]     b_idx_next [NUM_B];
  logic [NUM_LIGHT-1:0] l_full_next;
  logic [IDX_W-1:0]     l_idx_next [NUM_LIGHT];
  logic                 report;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PT_MIN:            cfg.pt_min            <= cfg_data;
        REG_ETA_LIMIT:         cfg.eta_limit         <= cfg_data[EDGE_W-1:0];
        REG_BARREL_EDGE:       cfg.barrel_edge       <= cfg_data[EDGE_W-1:0];
        REG_ENDCAP_EDGE:       cfg.endcap_edge       <= cfg_data[EDGE_W-1:0];
        REG_SPREAD_MAX_BARREL: cfg.spread_max_barrel <= cfg_data[SPREAD_W-1:0];
        REG_BETA_MAX_BARREL:   cfg.beta_max_barrel   <= cfg_data[BETA_W-1:0];
        REG_SPREAD_MAX_ENDCAP: cfg.spread_max_endcap <= cfg_data[SPREAD_W-1:0];
        REG_BETA_MAX_ENDCAP:   cfg.beta_max_endcap   <= cfg_data[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  // only a last jet needs room in the result register
  assign advance  = jet_valid && (!jet.last_jet || !out_valid || !out_stall);
  assign in_stall = jet_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      jet_valid <= 1'b0;
    end else if (!in_stall) begin
      jet_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      jet <= '{pt: pt, eta: eta, btag: btag, spread: spread,
               beta_star: beta_star, last_jet: last_jet};
    end
  end

  jqts_qualify u_qualify (
    .cfg_jet (jet),
    .cfg     (cfg),
    .pass    (pass)
  );

  assign in_range = (next_index < CNT_W'(MAX_JETS));
  assign jet_idx  = IDX_W'(next_index);
  assign report   = advance && jet.last_jet;

  always_comb begin
    b_ctrl.insert = advance && in_range && pass && jet.btag;
    b_ctrl.clear  = report;
    l_ctrl.insert = advance && in_range && pass && !jet.btag;
    l_ctrl.clear  = report;
  end

  always_ff @(posedge clk) begin
    if (rst || report) begin
      next_index <= '0;
    end else if (advance && in_range) begin
      next_index <= next_index + 1'b1;
    end
  end

  jqts_slots #(.NUM_SLOTS(NUM_B)) u_b_slots (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (b_ctrl),
    .pt        (jet.pt),
    .idx       (jet_idx),
    .full_next (b_full_next),
    .idx_next  (b_idx_next)
  );

  jqts_slots #(.NUM_SLOTS(NUM_LIGHT)) u_light_slots (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (l_ctrl),
    .pt        (jet.pt),
    .idx       (jet_idx),
    .full_next (l_full_next),
    .idx_next  (l_idx_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (report) begin
      b_first      <= b_full_next[0] ? b_idx_next[0] : '0;
      b_second     <= b_full_next[1] ? b_idx_next[1] : '0;
      b_third      <= b_full_next[2] ? b_idx_next[2] : '0;
      b_fourth     <= b_full_next[3] ? b_idx_next[3] : '0;
      light_first  <= l_full_next[0] ? l_idx_next[0] : '0;
      light_second <= l_full_next[1] ? l_idx_next[1] : '0;
      slot_valid   <= {l_full_next, b_full_next};
      complete     <= (&b_full_next) && (&l_full_next);
    end
  end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the jet qualify and top-k select core.
module tb;
  import jqts_pkg::*;

  localparam int MAX_JETS = 256;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [IDX_W-1:0] b_first;
    logic [IDX_W-1:0] b_second;
    logic [IDX_W-1:0] b_third;
    logic [IDX_W-1:0] b_fourth;
    logic [IDX_W-1:0] light_first;
    logic [IDX_W-1:0] light_second;
    logic [5:0]       slot_valid;
    logic             complete;
  } event_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  jet_t jet_out = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] b_first, b_second, b_third, b_fourth, light_first, light_second;
  logic [5:0] slot_valid;
  logic complete;

  jet_qualify_topk_select_core #(.MAX_JETS(MAX_JETS)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pt(jet_out.pt), .eta(jet_out.eta), .btag(jet_out.btag),
    .spread(jet_out.spread), .beta_star(jet_out.beta_star),
    .last_jet(jet_out.last_jet),
    .out_valid(out_valid), .out_stall(out_stall),
    .b_first(b_first), .b_second(b_second), .b_third(b_third), .b_fourth(b_fourth),
    .light_first(light_first), .light_second(light_second),
    .slot_valid(slot_valid), .complete(complete)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the cuts and the slot lists; slots 0-3 b, 4-5 light
  cfg_t cuts = CFG_RESET;
  logic [PT_W-1:0]  slot_pt[6];
  logic [IDX_W-1:0] slot_idx[6];
  logic             slot_full[6];
  int               jet_count = 0;

  jet_t          jets_pending[$];
  event_report_t reports_due[$];

  int  send_gap_pct = 0;
  int  stall_pct = 0;
  bit  pause_per_event = 0;
  bit  hold_for_reports = 0;
  logic jet_taken = 1'b0;
  int  mismatches = 0;
  int  jets_sent = 0;
  int  reports_seen = 0;
  int  settings_used = 1;

  task automatic note_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(string name, int got, int want);
    if (got != want)
      note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic logic jet_passes(jet_t j);
    logic [ETA_W-1:0] aeta;
    logic id_ok;
    aeta = j.eta[ETA_W-1] ? 11'd0 - j.eta : j.eta;
    if (aeta < cuts.barrel_edge)
      id_ok = (j.spread < cuts.spread_max_barrel) && (j.beta_star < cuts.beta_max_barrel);
    else if (aeta < cuts.endcap_edge)
      id_ok = (j.spread < cuts.spread_max_endcap) && (j.beta_star < cuts.beta_max_endcap);
    else
      id_ok = 1'b0;
    return id_ok && (j.pt > cuts.pt_min) && (aeta < cuts.eta_limit);
  endfunction

  // first slot that is empty or strictly lower takes the jet, the rest shift down
  task automatic slot_in(int lo, int hi, logic [PT_W-1:0] p, logic [IDX_W-1:0] ix);
    int k;
    int at;
    at = -1;
    for (k = lo; k <= hi; k++)
      if (at < 0 && (!slot_full[k] || p > slot_pt[k])) at = k;
    if (at >= 0) begin
      for (k = hi; k > at; k--) begin
        slot_pt[k] = slot_pt[k-1];
        slot_idx[k] = slot_idx[k-1];
        slot_full[k] = slot_full[k-1];
      end
      slot_pt[at] = p;
      slot_idx[at] = ix;
      slot_full[at] = 1'b1;
    end
  endtask

  task automatic clear_slots();
    int k;
    for (k = 0; k < 6; k++) begin
      slot_pt[k] = '0;
      slot_idx[k] = '0;
      slot_full[k] = 1'b0;
    end
    jet_count = 0;
  endtask

  task automatic predict_jet(jet_t j);
    event_report_t r;
    logic [IDX_W-1:0] shown[6];
    int k;
    if (jet_count < MAX_JETS) begin
      if (jet_passes(j)) begin
        if (j.btag) slot_in(0, 3, j.pt, 8'(jet_count));
        else        slot_in(4, 5, j.pt, 8'(jet_count));
      end
      jet_count++;
    end
    if (j.last_jet) begin
      for (k = 0; k < 6; k++) begin
        shown[k] = slot_full[k] ? slot_idx[k] : '0;
        r.slot_valid[k] = slot_full[k];
      end
      r.b_first = shown[0];
      r.b_second = shown[1];
      r.b_third = shown[2];
      r.b_fourth = shown[3];
      r.light_first = shown[4];
      r.light_second = shown[5];
      r.complete = &r.slot_valid;
      reports_due.push_back(r);
      clear_slots();
    end
  endtask

  // sender: new word on the falling edge unless the current one is still stalled
  always @(negedge clk) begin : drive_jets
    jet_t nxt;
    if (!(in_valid && !jet_taken)) begin
      if (hold_for_reports && reports_due.size() == 0) hold_for_reports = 0;
      if (!rst && !hold_for_reports && jets_pending.size() != 0 &&
          $urandom_range(99) >= send_gap_pct) begin
        nxt = jets_pending.pop_front();
        jet_out <= nxt;
        in_valid <= 1'b1;
        jets_sent++;
        if (nxt.last_jet && pause_per_event) hold_for_reports = 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : watch
    event_report_t want;
    jet_taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) predict_jet(jet_out);
    if (!rst && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        note_mismatch("event report with none pending");
      end else begin
        want = reports_due.pop_front();
        cmp_field("b_first", int'(b_first), int'(want.b_first));
        cmp_field("b_second", int'(b_second), int'(want.b_second));
        cmp_field("b_third", int'(b_third), int'(want.b_third));
        cmp_field("b_fourth", int'(b_fourth), int'(want.b_fourth));
        cmp_field("light_first", int'(light_first), int'(want.light_first));
        cmp_field("light_second", int'(light_second), int'(want.light_second));
        cmp_field("slot_valid", int'(slot_valid), int'(want.slot_valid));
        cmp_field("complete", int'(complete), int'(want.complete));
        reports_seen++;
      end
    end
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PT_MIN:            cuts.pt_min = val;
      REG_ETA_LIMIT:         cuts.eta_limit = val[9:0];
      REG_BARREL_EDGE:       cuts.barrel_edge = val[9:0];
      REG_ENDCAP_EDGE:       cuts.endcap_edge = val[9:0];
      REG_SPREAD_MAX_BARREL: cuts.spread_max_barrel = val[9:0];
      REG_BETA_MAX_BARREL:   cuts.beta_max_barrel = val[10:0];
      REG_SPREAD_MAX_ENDCAP: cuts.spread_max_endcap = val[9:0];
      REG_BETA_MAX_ENDCAP:   cuts.beta_max_endcap = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int p, int el, int be, int ee, int sb, int bb, int se, int bn);
    set_reg(REG_PT_MIN, 16'(p));
    set_reg(REG_ETA_LIMIT, 16'(el));
    set_reg(REG_BARREL_EDGE, 16'(be));
    set_reg(REG_ENDCAP_EDGE, 16'(ee));
    set_reg(REG_SPREAD_MAX_BARREL, 16'(sb));
    set_reg(REG_BETA_MAX_BARREL, 16'(bb));
    set_reg(REG_SPREAD_MAX_ENDCAP, 16'(se));
    set_reg(REG_BETA_MAX_ENDCAP, 16'(bn));
    settings_used++;
  endtask

  task automatic wait_for_quiet();
    while (jets_pending.size() != 0 || in_valid || reports_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic jet_t jet_of(int p, int e, bit b, int s, int bs, bit last);
    jet_t j;
    j.pt = 16'(p);
    j.eta = 11'(e);
    j.btag = b;
    j.spread = 10'(s);
    j.beta_star = 11'(bs);
    j.last_jet = last;
    return j;
  endfunction

  // mostly near the cuts, with ties on pt and boundary values thrown in
  function automatic jet_t random_jet(bit last);
    jet_t j;
    int cap;
    int aeta;
    int lim;
    case ($urandom_range(9))
      0: j.pt = 16'($urandom);
      1: j.pt = cuts.pt_min;
      2: j.pt = cuts.pt_min + 16'd1;
      3: j.pt = 16'hFFFF;
      4: j.pt = '0;
      default: j.pt = (cuts.pt_min > 65535 - 48) ? 16'($urandom) :
                      cuts.pt_min + 16'($urandom_range(1, 48));
    endcase
    cap = (cuts.endcap_edge < cuts.eta_limit) ? int'(cuts.endcap_edge) : int'(cuts.eta_limit);
    if ($urandom_range(9) == 0) begin
      j.eta = 11'($urandom);
    end else begin
      case ($urandom_range(7))
        0: aeta = int'(cuts.barrel_edge);
        1: aeta = cap;
        default: aeta = (cap > 0) ? int'($urandom_range(cap - 1)) : 0;
      endcase
      j.eta = $urandom_range(1) ? 11'(-aeta) : 11'(aeta);
    end
    j.btag = ($urandom_range(2) != 0);
    lim = (cuts.spread_max_barrel < cuts.spread_max_endcap) ?
          int'(cuts.spread_max_barrel) : int'(cuts.spread_max_endcap);
    case ($urandom_range(5))
      0: j.spread = 10'($urandom);
      1: j.spread = cuts.spread_max_barrel;
      default: j.spread = (lim > 0) ? 10'($urandom_range(lim - 1)) : '0;
    endcase
    lim = (cuts.beta_max_barrel < cuts.beta_max_endcap) ?
          int'(cuts.beta_max_barrel) : int'(cuts.beta_max_endcap);
    if (lim > 1024) lim = 1024;
    case ($urandom_range(5))
      0: j.beta_star = 11'($urandom_range(1024));
      1: j.beta_star = (cuts.beta_max_endcap > 1024) ? 11'd1024 : cuts.beta_max_endcap;
      default: j.beta_star = (lim > 0) ? 11'($urandom_range(lim - 1)) : '0;
    endcase
    j.last_jet = last;
    return j;
  endfunction

  function automatic jet_t raw_jet();
    return jet_of($urandom, $urandom, 1'($urandom_range(1)), $urandom,
                  int'($urandom_range(1024)), $urandom_range(3) == 0);
  endfunction

  // mostly whole events of random length, some raw noise; always closed by a last jet
  task automatic queue_events(int n_items);
    int done;
    int len;
    int k;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) jets_pending.push_back(raw_jet());
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
        for (k = 1; k <= len; k++) jets_pending.push_back(random_jet(k == len));
      end
      done += len;
    end
    jets_pending.push_back(random_jet(1'b1));
  endtask

  initial begin : stimulus
    int k;
    clear_slots();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: sorting, ties, third-slot insertion, each cut edge, empty and lone events
    jets_pending.push_back(jet_of(1000, 0, 1, 0, 0, 0));
    jets_pending.push_back(jet_of(800, 25, 1, 10, 100, 0));
    jets_pending.push_back(jet_of(400, -75, 1, 10, 100, 0));
    jets_pending.push_back(jet_of(500, 100, 1, 10, 100, 0));
    jets_pending.push_back(jet_of(800, 149, 1, 71, 890, 0));
    jets_pending.push_back(jet_of(65535, -399, 0, 71, 869, 0));
    jets_pending.push_back(jet_of(161, -149, 0, 0, 0, 0));
    jets_pending.push_back(jet_of(160, 0, 0, 0, 0, 0));
    jets_pending.push_back(jet_of(2000, 400, 1, 0, 0, 0));
    jets_pending.push_back(jet_of(2000, -1024, 1, 0, 0, 0));
    jets_pending.push_back(jet_of(2000, 0, 1, 72, 0, 0));
    jets_pending.push_back(jet_of(2000, 0, 1, 0, 891, 0));
    jets_pending.push_back(jet_of(3000, 150, 1, 0, 870, 0));
    jets_pending.push_back(jet_of(0, 0, 0, 0, 0, 1));
    jets_pending.push_back(jet_of(0, 1023, 1, 1023, 1024, 1));
    jets_pending.push_back(jet_of(65535, 0, 0, 0, 0, 1));
    jets_pending.push_back(jet_of(170, 0, 1, 0, 0, 0));
    jets_pending.push_back(jet_of(170, 0, 1, 0, 0, 0));
    jets_pending.push_back(jet_of(200, 0, 0, 0, 0, 0));
    jets_pending.push_back(jet_of(171, -1, 1, 0, 0, 1));
    queue_events(250);
    wait_for_quiet();

    // moderate random cuts, sender gaps
    set_all($urandom_range(100, 600), $urandom_range(200, 1023), $urandom_range(0, 400),
            $urandom_range(100, 1023), $urandom_range(20, 1023), $urandom_range(300, 1024),
            $urandom_range(20, 1023), $urandom_range(300, 1024));
    send_gap_pct = 47;
    queue_events(300);
    wait_for_quiet();

    // loosest cuts, receiver stalls; one event past the index limit
    set_all(0, 1023, 1023, 1023, 1023, 1024, 1023, 1024);
    send_gap_pct = 0;
    stall_pct = 47;
    for (k = 0; k < 270; k++) jets_pending.push_back(random_jet(k == 269));
    queue_events(100);
    wait_for_quiet();

    // tightest cuts: nothing qualifies
    set_all(65535, 0, 0, 0, 0, 0, 0, 0);
    send_gap_pct = 17;
    stall_pct = 17;
    queue_events(150);
    wait_for_quiet();

    // raw register data, unused indices, sender waits out each report
    set_reg(REG_UNUSED_LO, 16'($urandom));
    set_reg(REG_UNUSED_HI, 16'($urandom));
    set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    pause_per_event = 1;
    queue_events(250);
    wait_for_quiet();

    repeat (8) @(posedge clk);
    $display("Sent %0d jets under %0d cut settings, checked %0d event reports",
             jets_sent, settings_used, reports_seen);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #(8 * 400000);
    $display("Timed out with %0d reports pending", reports_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/jqts_pkg.sv
rtl/jqts_qualify.sv
rtl/jqts_slots.sv
rtl/jet_qualify_topk_select_core.sv
dv/tb.sv
